@@ hdl/scal_pkg.sv @@
// shared types and constants of the assignment-literal scanner
// no dependencies; used by every module of the block
`default_nettype none

package scal_pkg;

  // literal store size: MAX_LITERAL held to 1..32
  localparam int MaxLiteral  = 32;
  localparam int ResultLimit = 32;
  localparam int LitCap      = (MaxLiteral < 1) ? 1 :
                               ((MaxLiteral > ResultLimit) ? ResultLimit : MaxLiteral);
  localparam int LitAddrW    = (LitCap > 1) ? $clog2(LitCap) : 1;
  localparam int LenW        = $clog2(LitCap + 1);

  // run queue between front and back
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] literal_byte;
    logic       byte_valid;
    logic       truncated;
    logic       run_last;
  } out_t;

  // one run to emit: found literal of len bytes, or not-found
  typedef struct packed {
    logic            found;
    logic [LenW-1:0] len;
    logic            ovf;
  } run_t;

  // literal store write from front to back
  typedef struct packed {
    logic                en;
    logic [LitAddrW-1:0] addr;
    logic [7:0]          data;
  } wr_t;

endpackage

`default_nettype wire

@@ hdl/scal_fifo.sv @@
// short run queue between the front and back parts
// depends on scal_pkg (run_t, QueueDepth)
`default_nettype none

module scal_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  scal_pkg::run_t     push_data_i,
  input  wire logic          pop_i,
  output scal_pkg::run_t     pop_data_o,
  output logic               full_o,
  output logic               empty_o
);

  scal_pkg::run_t                 mem_q [scal_pkg::QueueDepth];
  logic [scal_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [scal_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [scal_pkg::QPtrW:0]       cnt_q, cnt_d;

  assign full_o     = (cnt_q == (scal_pkg::QPtrW + 1)'(scal_pkg::QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == scal_pkg::QPtrW'(scal_pkg::QueueDepth - 1)) ? '0 :
                 scal_pkg::QPtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == scal_pkg::QPtrW'(scal_pkg::QueueDepth - 1)) ? '0 :
                 scal_pkg::QPtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("run queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("run queue read while empty");

endmodule

`default_nettype wire

@@ hdl/scal_front.sv @@
// front part: lexer, token and assignment matcher, literal store writes
// depends on scal_pkg (in_t, run_t, wr_t, LitCap)
`default_nettype none

module scal_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  scal_pkg::in_t    in_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output scal_pkg::run_t   q_data_o,
  input  wire logic        run_done_i,
  output scal_pkg::wr_t    wr_o
);

  typedef enum logic [2:0] {
    ModeCode, ModeLine, ModeBlock, ModeStr, ModeChr
  } lex_mode_e;

  typedef enum logic [2:0] {
    PhIdle, PhToken, PhAfter, PhWs1, PhWs2, PhLit
  } match_e;

  typedef struct packed {
    lex_mode_e                 mode;
    logic                      ps;
    logic                      bs;
    logic                      esc;
    logic [7:0]                prior;
    logic [3:0]                tidx;
    match_e                    phase;
    logic [scal_pkg::LenW-1:0] llen;
    logic                      ovf;
    logic                      done;
  } lex_t;

  localparam logic [3:0] TokLen   = 4'd12;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChEq     = 8'h3D;

  localparam lex_t LexReset = '{
    mode: ModeCode, ps: 1'b0, bs: 1'b0, esc: 1'b0, prior: 8'h0A, tidx: 4'd0,
    phase: PhIdle, llen: '0, ovf: 1'b0, done: 1'b0
  };

  function automatic logic is_ident(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || (c == "_");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

  // characters of the searched token
  function automatic logic [7:0] tok_char(logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = "a";
      4'd1:    r = "l";
      4'd2:    r = "g";
      4'd3:    r = "o";
      4'd4:    r = "_";
      4'd5:    r = "v";
      4'd6:    r = "e";
      4'd7:    r = "r";
      4'd8:    r = "s";
      4'd9:    r = "i";
      4'd10:   r = "o";
      4'd11:   r = "n";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // a code byte with no match under way
  function automatic lex_t code_byte(lex_t s, logic [7:0] c);
    lex_t r;
    logic taken;
    r       = s;
    taken   = 1'b0;
    r.phase = PhIdle;
    r.tidx  = 4'd0;
    if (r.ps) begin
      r.ps = 1'b0;
      if (c == ChSlash) begin
        r.mode = ModeLine;
        taken  = 1'b1;
      end else if (c == ChStar) begin
        r.mode = ModeBlock;
        r.bs   = 1'b0;
        taken  = 1'b1;
      end
    end
    if (!taken) begin
      if (c == ChSlash) begin
        r.ps = 1'b1;
      end else if (c == ChDquote) begin
        r.mode = ModeStr;
        r.esc  = 1'b0;
      end else if (c == ChSquote) begin
        r.mode = ModeChr;
        r.esc  = 1'b0;
      end else if (c == "a" && !is_ident(s.prior)) begin
        r.phase = PhToken;
        r.tidx  = 4'd1;
      end
    end
    return r;
  endfunction

  lex_t                      st_q, st_d;
  logic [1:0]                busy_q, busy_d;
  logic                      accept;
  logic                      push;
  scal_pkg::run_t            run;
  scal_pkg::wr_t             wr;
  logic                      go_on;
  logic [7:0]                c;

  assign c          = in_i.text_byte;
  // hold off while a found literal still sits in the store and would be overwritten
  assign in_ready_o = !q_full_i && !(st_q.phase == PhLit && busy_q != 2'd0);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    st_d    = st_q;
    push    = 1'b0;
    run     = '0;
    wr      = '0;
    wr.data = c;
    go_on   = 1'b1;
    if (st_q.done) begin
      if (in_i.text_end) begin
        st_d = LexReset;
      end
    end else begin
      case (st_q.mode)
        ModeLine: begin
          if (c == ChLf) st_d.mode = ModeCode;
        end
        ModeBlock: begin
          if (st_q.bs && c == ChSlash) begin
            st_d.mode = ModeCode;
            st_d.bs   = 1'b0;
          end else begin
            st_d.bs = (c == ChStar);
          end
        end
        ModeStr, ModeChr: begin
          if (st_q.esc) begin
            st_d.esc = 1'b0;
          end else if (c == ChBslash) begin
            st_d.esc = 1'b1;
          end else if (c == ((st_q.mode == ModeStr) ? ChDquote : ChSquote)) begin
            st_d.mode = ModeCode;
          end
        end
        default: begin
          st_d.mode = ModeCode;
          if (st_q.phase == PhToken) begin
            if (st_q.tidx < TokLen && c == tok_char(st_q.tidx)) begin
              st_d.tidx = st_q.tidx + 4'd1;
              if (st_d.tidx >= TokLen) st_d.phase = PhAfter;
            end else begin
              st_d = code_byte(st_d, c);
            end
          end else begin
            if (st_q.phase == PhAfter) begin
              if (is_ident(c)) begin
                st_d  = code_byte(st_d, c);
                go_on = 1'b0;
              end else begin
                st_d.phase = PhWs1;
                st_d.tidx  = 4'd0;
              end
            end
            if (go_on) begin
              if (st_d.phase == PhWs1) begin
                if (c == ChEq) st_d.phase = PhWs2;
                else if (!is_space(c)) st_d = code_byte(st_d, c);
              end else if (st_d.phase == PhWs2) begin
                if (c == ChDquote) begin
                  st_d.phase = PhLit;
                  st_d.llen  = '0;
                  st_d.ovf   = 1'b0;
                end else if (!is_space(c)) begin
                  st_d = code_byte(st_d, c);
                end
              end else if (st_d.phase == PhLit) begin
                if (c == ChDquote) begin
                  st_d.done  = 1'b1;
                  st_d.phase = PhIdle;
                end else if (c == ChLf) begin
                  st_d.phase = PhIdle;
                  st_d.mode  = ModeStr;
                  st_d.esc   = 1'b0;
                end else if (st_d.llen < scal_pkg::LenW'(scal_pkg::LitCap)) begin
                  wr.en     = 1'b1;
                  wr.addr   = st_d.llen[scal_pkg::LitAddrW-1:0];
                  st_d.llen = st_d.llen + scal_pkg::LenW'(1);
                end else begin
                  st_d.ovf = 1'b1;
                end
              end else begin
                st_d = code_byte(st_d, c);
              end
            end
          end
        end
      endcase
      st_d.prior = c;
      if (st_d.done) begin
        push      = 1'b1;
        run.found = 1'b1;
        run.len   = st_d.llen;
        run.ovf   = st_d.ovf;
      end else if (in_i.text_end) begin
        push = 1'b1;
      end
      if (in_i.text_end) begin
        st_d = LexReset;
      end
    end
  end

  // found runs queued or being emitted by the back part
  always_comb begin
    busy_d = busy_q;
    if (accept && push && run.found && !run_done_i) begin
      busy_d = busy_q + 2'd1;
    end else if (!(accept && push && run.found) && run_done_i) begin
      busy_d = busy_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LexReset;
      busy_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        st_q <= st_d;
      end
    end
  end

  assign q_push_o = accept && push;
  assign q_data_o = run;
  assign wr_o     = '{en: accept && wr.en, addr: wr.addr, data: wr.data};

  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> busy_q == 2'd0)
    else $error("literal store written while a found run is pending");

endmodule

`default_nettype wire

@@ hdl/scal_back.sv @@
// back part: literal store and result emitter with output register
// depends on scal_pkg (run_t, wr_t, out_t, LitCap)
`default_nettype none

module scal_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  scal_pkg::wr_t    wr_i,
  input  wire logic        q_empty_i,
  input  scal_pkg::run_t   q_data_i,
  output logic             q_pop_o,
  output logic             run_done_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output scal_pkg::out_t   out_o
);

  typedef enum logic [1:0] {
    BIdle, BRead, BLoad
  } back_state_e;

  logic [7:0]                store_q [scal_pkg::LitCap];
  logic [7:0]                rdata_q;
  back_state_e               state_q;
  logic [scal_pkg::LenW-1:0] k_q;
  logic [scal_pkg::LenW-1:0] len_q;
  logic                      ovf_q;
  logic                      out_valid_q;
  scal_pkg::out_t            out_q;
  logic                      slot_free;
  logic                      last_byte;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign q_pop_o     = (state_q == BIdle) && !q_empty_i && slot_free;
  assign last_byte   = (scal_pkg::LenW'(k_q + scal_pkg::LenW'(1)) == len_q);
  assign run_done_o  = (q_pop_o && q_data_i.found && q_data_i.len == '0) ||
                       ((state_q == BLoad) && slot_free && last_byte);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BIdle: begin
          if (q_pop_o) begin
            if (!q_data_i.found || q_data_i.len == '0) begin
              out_valid_q <= 1'b1;
              out_q       <= '{found: q_data_i.found, literal_byte: 8'h00,
                               byte_valid: 1'b0, truncated: 1'b0, run_last: 1'b1};
            end else begin
              len_q   <= q_data_i.len;
              ovf_q   <= q_data_i.ovf;
              k_q     <= '0;
              state_q <= BRead;
            end
          end
        end
        BRead: begin
          rdata_q <= store_q[k_q[scal_pkg::LitAddrW-1:0]];
          state_q <= BLoad;
        end
        BLoad: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q       <= '{found: 1'b1, literal_byte: rdata_q, byte_valid: 1'b1,
                             truncated: ovf_q, run_last: last_byte};
            if (last_byte) begin
              state_q <= BIdle;
            end else begin
              k_q     <= k_q + scal_pkg::LenW'(1);
              state_q <= BRead;
            end
          end
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  a_read_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BRead |-> k_q < len_q)
    else $error("store read past the literal length");

  a_byte_means_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.byte_valid |-> out_q.found)
    else $error("literal byte shown on a not-found result");

  a_notfound_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.run_last && !out_q.truncated)
    else $error("not-found result is not a single closed run");

endmodule

`default_nettype wire

@@ hdl/c_source_assignment_literal_scanner_top.sv @@
// top level of the assignment-literal scanner: front, run queue, back
// depends on scal_pkg, scal_front, scal_fifo, scal_back
`default_nettype none

// usage
//   in channel: one text byte per beat (text_byte, text_end on the last byte of a text)
//   out channel: result beats; a run is either the bytes of the value quoted after
//     "algo_version =" (found = 1, truncated when longer than the store) or one
//     not-found beat at the end of a text; run_last closes each run
//   the front lexer takes one byte per cycle; it holds in_ready low only when the
//     run queue is full, or when a new literal would overwrite the store while an
//     earlier found run is still queued or being emitted
//   a not-found or empty-literal beat passes through the run queue and then the
//     output register; a found literal's first byte passes through the run queue,
//     the store read register and then the output register
//   the back part emits each literal byte by a store read and then a load into
//     the output register; the load waits while the output register is held
//   the run queue parts the two sides, so the input keeps moving while a
//     result waits; a stalled receiver backs up the queue and then the input
//   reset clears lexer, queue and emitter; the literal store needs no clearing
//   after the last byte of a text the lexer returns to its start state
module c_source_assignment_literal_scanner_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  scal_pkg::in_t    in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output scal_pkg::out_t   out_o
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  logic           run_done;
  scal_pkg::run_t q_wdata;
  scal_pkg::run_t q_rdata;
  scal_pkg::wr_t  store_wr;

  // lexer and matcher
  scal_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .run_done_i (run_done),
    .wr_o       (store_wr)
  );

  // run descriptors between the two parts
  scal_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // literal store and emitter
  scal_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (store_wr),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .run_done_o  (run_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
